>>> src/evg_pkg.sv
package evg_pkg;

   localparam int unsigned MAX_SEGMENTS_DEF = 65536;
   localparam int unsigned MIN_SEGMENTS     = 3;
   localparam int          DIV_STEPS        = 32;
   localparam int          CORDIC_STEPS     = 28;
   localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

   typedef enum logic [2:0] {
      CSR_CENTER_X      = 3'd0,
      CSR_CENTER_Y      = 3'd1,
      CSR_SEMI_MAJOR    = 3'd2,
      CSR_SEMI_MINOR    = 3'd3,
      CSR_AZIMUTH_TURNS = 3'd4,
      CSR_SEGMENT_COUNT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic ok;
   } tag_type;

   // arctan(2^-k) in units of 2^-32 turn
   function automatic logic signed [31:0] atan_turn(input int k);
      logic signed [31:0] v;
      case (k)
         0:  v = 32'sh20000000;
         1:  v = 32'sh12E4051E;
         2:  v = 32'sh09FB385B;
         3:  v = 32'sh051111D4;
         4:  v = 32'sh028B0D43;
         5:  v = 32'sh0145D7E1;
         6:  v = 32'sh00A2F61E;
         7:  v = 32'sh00517C55;
         8:  v = 32'sh0028BE53;
         9:  v = 32'sh00145F2F;
         10: v = 32'sh000A2F98;
         11: v = 32'sh000517CC;
         12: v = 32'sh00028BE6;
         13: v = 32'sh000145F3;
         14: v = 32'sh0000A2FA;
         15: v = 32'sh0000517D;
         16: v = 32'sh000028BE;
         17: v = 32'sh0000145F;
         18: v = 32'sh00000A30;
         19: v = 32'sh00000518;
         20: v = 32'sh0000028C;
         21: v = 32'sh00000146;
         22: v = 32'sh000000A3;
         23: v = 32'sh00000051;
         24: v = 32'sh00000029;
         25: v = 32'sh00000014;
         26: v = 32'sh0000000A;
         27: v = 32'sh00000005;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> src/evg_divider.sv
module evg_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  evg_pkg::tag_type in_tag,
   input  logic [15:0]      point_index,
   input  logic [16:0]      segment_count,
   output evg_pkg::tag_type out_tag,
   output logic [31:0]      phase
);
   import evg_pkg::*;

   // restoring division, one quotient bit per stage:
   // phase = ((N-i)*2^32 + N/2) / N
   logic [16:0] r_ff   [0:DIV_STEPS];
   logic [16:0] r_in   [0:DIV_STEPS];
   logic [31:0] q_ff   [0:DIV_STEPS];
   logic [31:0] q_in   [0:DIV_STEPS];
   logic        zero_ff[0:DIV_STEPS];
   logic        zero_in[0:DIV_STEPS];
   tag_type     tag_ff [0:DIV_STEPS];
   tag_type     tag_in [0:DIV_STEPS];
   logic [17:0] trial  [0:DIV_STEPS-1];
   logic        ge     [0:DIV_STEPS-1];
   logic [31:0] half;

   assign half = 32'(segment_count >> 1);

   always_comb begin
      r_in[0]    = segment_count - 17'(point_index);
      q_in[0]    = '0;
      zero_in[0] = (point_index == '0);
      tag_in[0]  = in_tag;
      for (int k = 0; k < DIV_STEPS; k++) begin
         trial[k]     = {r_ff[k], half[DIV_STEPS-1-k]};
         ge[k]        = (trial[k] >= {1'b0, segment_count});
         r_in[k+1]    = ge[k] ? 17'(trial[k] - {1'b0, segment_count}) : trial[k][16:0];
         q_in[k+1]    = {q_ff[k][30:0], ge[k]};
         zero_in[k+1] = zero_ff[k];
         tag_in[k+1]  = tag_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            r_ff[k]    <= r_in[k];
            q_ff[k]    <= q_in[k];
            zero_ff[k] <= zero_in[k];
         end
      end
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            tag_ff[k] <= '0;
         end
      end else if (enable) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            tag_ff[k] <= tag_in[k];
         end
      end
   end

   // index zero sits at a full turn, which wraps to zero
   assign phase   = zero_ff[DIV_STEPS] ? '0 : q_ff[DIV_STEPS];
   assign out_tag = tag_ff[DIV_STEPS];

endmodule

>>> src/evg_cordic.sv
module evg_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  evg_pkg::tag_type    in_tag,
   input  logic [31:0]         phase,
   input  logic [15:0]         azimuth_turns,
   output evg_pkg::tag_type    out_tag,
   output logic signed [31:0]  cos_t,
   output logic signed [31:0]  sin_t,
   output logic signed [31:0]  cos_a,
   output logic signed [31:0]  sin_a
);
   import evg_pkg::*;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   // lane 0: vertex angle, lane 1: azimuth
   logic signed [31:0] x_ff [0:CORDIC_STEPS][0:1];
   logic signed [31:0] x_in [0:CORDIC_STEPS][0:1];
   logic signed [31:0] y_ff [0:CORDIC_STEPS][0:1];
   logic signed [31:0] y_in [0:CORDIC_STEPS][0:1];
   logic signed [31:0] z_ff [0:CORDIC_STEPS][0:1];
   logic signed [31:0] z_in [0:CORDIC_STEPS][0:1];
   logic [1:0]         q_ff [0:CORDIC_STEPS][0:1];
   logic [1:0]         q_in [0:CORDIC_STEPS][0:1];
   tag_type            tag_ff[0:CORDIC_STEPS];
   tag_type            tag_in[0:CORDIC_STEPS];
   logic [31:0]        angle [0:1];
   logic [31:0]        bias  [0:1];
   logic signed [31:0] c_in  [0:1];
   logic signed [31:0] s_in  [0:1];
   logic signed [31:0] c_ff  [0:1];
   logic signed [31:0] s_ff  [0:1];
   tag_type            out_tag_ff;

   assign angle[0] = phase;
   assign angle[1] = {azimuth_turns, 16'b0};

   always_comb begin
      tag_in[0] = in_tag;
      for (int l = 0; l < 2; l++) begin
         // strip nearest quadrant, residual in [-1/8, 1/8) turn
         bias[l]    = angle[l] + 32'h2000_0000;
         q_in[0][l] = bias[l][31:30];
         z_in[0][l] = $signed(angle[l] - {bias[l][31:30], 30'b0});
         x_in[0][l] = CORDIC_X0;
         y_in[0][l] = '0;
      end
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         tag_in[k+1] = tag_ff[k];
         for (int l = 0; l < 2; l++) begin
            q_in[k+1][l] = q_ff[k][l];
            if (!z_ff[k][l][31]) begin
               x_in[k+1][l] = x_ff[k][l] - (y_ff[k][l] >>> k);
               y_in[k+1][l] = y_ff[k][l] + (x_ff[k][l] >>> k);
               z_in[k+1][l] = z_ff[k][l] - atan_turn(k);
            end else begin
               x_in[k+1][l] = x_ff[k][l] + (y_ff[k][l] >>> k);
               y_in[k+1][l] = y_ff[k][l] - (x_ff[k][l] >>> k);
               z_in[k+1][l] = z_ff[k][l] + atan_turn(k);
            end
         end
      end
      for (int l = 0; l < 2; l++) begin
         case (q_ff[CORDIC_STEPS][l])
            QUAD_0: begin
               c_in[l] = x_ff[CORDIC_STEPS][l];
               s_in[l] = y_ff[CORDIC_STEPS][l];
            end
            QUAD_1: begin
               c_in[l] = -y_ff[CORDIC_STEPS][l];
               s_in[l] = x_ff[CORDIC_STEPS][l];
            end
            QUAD_2: begin
               c_in[l] = -x_ff[CORDIC_STEPS][l];
               s_in[l] = -y_ff[CORDIC_STEPS][l];
            end
            default: begin
               c_in[l] = y_ff[CORDIC_STEPS][l];
               s_in[l] = -x_ff[CORDIC_STEPS][l];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            for (int l = 0; l < 2; l++) begin
               x_ff[k][l] <= x_in[k][l];
               y_ff[k][l] <= y_in[k][l];
               z_ff[k][l] <= z_in[k][l];
               q_ff[k][l] <= q_in[k][l];
            end
         end
         for (int l = 0; l < 2; l++) begin
            c_ff[l] <= c_in[l];
            s_ff[l] <= s_in[l];
         end
      end
      if (reset) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            tag_ff[k] <= '0;
         end
         out_tag_ff <= '0;
      end else if (enable) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            tag_ff[k] <= tag_in[k];
         end
         out_tag_ff <= tag_ff[CORDIC_STEPS];
      end
   end

   assign out_tag = out_tag_ff;
   assign cos_t   = c_ff[0];
   assign sin_t   = s_ff[0];
   assign cos_a   = c_ff[1];
   assign sin_a   = s_ff[1];

endmodule

>>> src/evg_mac.sv
module evg_mac (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  evg_pkg::tag_type   in_tag,
   input  logic signed [31:0] cos_t,
   input  logic signed [31:0] sin_t,
   input  logic signed [31:0] cos_a,
   input  logic signed [31:0] sin_a,
   input  logic signed [31:0] center_x,
   input  logic signed [31:0] center_y,
   input  logic [30:0]        semi_major,
   input  logic [30:0]        semi_minor,
   output evg_pkg::tag_type   out_tag,
   output logic signed [31:0] out_x,
   output logic signed [31:0] out_y,
   output logic               point_valid
);
   import evg_pkg::*;

   localparam logic signed [63:0] RND1 = 64'sd536870912;
   localparam logic signed [65:0] RND2 = 66'sd536870912;

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      logic signed [31:0] r;
      if (v > 38'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -38'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   logic signed [63:0] ac_full, bs_full;
   logic signed [33:0] ac_ff, bs_ff;
   logic signed [31:0] ca_ff, sa_ff;
   logic signed [65:0] xa_full, xb_full, ya_full, yb_full;
   logic signed [35:0] xa_ff, xb_ff, ya_ff, yb_ff;
   logic signed [37:0] x_sum, y_sum;
   logic signed [31:0] x_ff, y_ff;
   logic               pv_ff;
   tag_type            tag1_ff, tag2_ff, tag3_ff;

   // stage 1: axis times angle cos/sin, rounded half up to Q16.16
   assign ac_full = (64'($signed({1'b0, semi_major})) * 64'(cos_t)) + RND1;
   assign bs_full = (64'($signed({1'b0, semi_minor})) * 64'(sin_t)) + RND1;
   // stage 2: rotation by azimuth
   assign xa_full = (66'(ac_ff) * 66'(ca_ff)) + RND2;
   assign xb_full = (66'(bs_ff) * 66'(sa_ff)) + RND2;
   assign ya_full = (66'(ac_ff) * 66'(sa_ff)) + RND2;
   assign yb_full = (66'(bs_ff) * 66'(ca_ff)) + RND2;
   // stage 3: exact sum, then clamp
   assign x_sum = 38'(center_x) + 38'(xa_ff) - 38'(xb_ff);
   assign y_sum = 38'(center_y) + 38'(ya_ff) + 38'(yb_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         ac_ff <= 34'(ac_full >>> 30);
         bs_ff <= 34'(bs_full >>> 30);
         ca_ff <= cos_a;
         sa_ff <= sin_a;
         xa_ff <= 36'(xa_full >>> 30);
         xb_ff <= 36'(xb_full >>> 30);
         ya_ff <= 36'(ya_full >>> 30);
         yb_ff <= 36'(yb_full >>> 30);
         x_ff  <= tag2_ff.ok ? sat32(x_sum) : '0;
         y_ff  <= tag2_ff.ok ? sat32(y_sum) : '0;
         pv_ff <= tag2_ff.ok;
      end
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else if (enable) begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   assign out_tag     = tag3_ff;
   assign out_x       = x_ff;
   assign out_y       = y_ff;
   assign point_valid = pv_ff;

endmodule

>>> src/ellipse_vertex_generator_unit.sv
// Rotated-ellipse vertex generator. Each req item carries a vertex index i; the
// rsp item returns the Q16.16 point at angle 2*pi*(N-i)/N (clockwise walk)
// on the ellipse set by the csr registers, saturated to 32 bits, with tuser
// low and zero coordinates when N < 3, N > MAX_SEGMENTS or i >= N. The block
// is a 66-stage pipeline: 33 stages of one-bit-per-stage phase division,
// 30 stages of a 28-step CORDIC run for angle and azimuth side by side, and
// 3 multiply/sum stages. It takes one item per cycle when not stalled.
// A stalled rsp side freezes the whole pipeline. Write csr registers only
// while no items are in flight.
module ellipse_vertex_generator_unit #(
   parameter int unsigned MAX_SEGMENTS = evg_pkg::MAX_SEGMENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] point_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] out_x, [63:32] out_y
   output logic [0:0]  rsp_tuser,   // [0] point_valid
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import evg_pkg::*;

   logic signed [31:0] center_x_ff, center_y_ff;
   logic [30:0]        semi_major_ff, semi_minor_ff;
   logic [15:0]        azimuth_ff;
   logic [16:0]        segment_count_ff;
   logic               enable;
   logic               in_ok;
   tag_type            in_tag, div_tag, cor_tag, mac_tag;
   logic [31:0]        phase;
   logic signed [31:0] cos_t, sin_t, cos_a, sin_a, out_x, out_y;
   logic               point_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff      <= '0;
         center_y_ff      <= '0;
         semi_major_ff    <= 31'd655360;
         semi_minor_ff    <= 31'd327680;
         azimuth_ff       <= 16'd8192;
         segment_count_ff <= 17'd4;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER_X:      center_x_ff      <= csr_wdata;
            CSR_CENTER_Y:      center_y_ff      <= csr_wdata;
            CSR_SEMI_MAJOR:    semi_major_ff    <= csr_wdata[30:0];
            CSR_SEMI_MINOR:    semi_minor_ff    <= csr_wdata[30:0];
            CSR_AZIMUTH_TURNS: azimuth_ff       <= csr_wdata[15:0];
            CSR_SEGMENT_COUNT: segment_count_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   assign enable     = !mac_tag.valid || rsp_tready;
   assign req_tready = enable;

   assign in_ok = (32'(segment_count_ff) >= MIN_SEGMENTS)
               && (32'(segment_count_ff) <= MAX_SEGMENTS)
               && (17'(req_tdata) < segment_count_ff);
   assign in_tag = '{valid: req_tvalid, ok: in_ok};

   evg_divider u_div (
      .clock(clock), .reset(reset), .enable(enable),
      .in_tag(in_tag), .point_index(req_tdata),
      .segment_count(segment_count_ff),
      .out_tag(div_tag), .phase(phase)
   );

   evg_cordic u_cordic (
      .clock(clock), .reset(reset), .enable(enable),
      .in_tag(div_tag), .phase(phase), .azimuth_turns(azimuth_ff),
      .out_tag(cor_tag),
      .cos_t(cos_t), .sin_t(sin_t), .cos_a(cos_a), .sin_a(sin_a)
   );

   evg_mac u_mac (
      .clock(clock), .reset(reset), .enable(enable),
      .in_tag(cor_tag),
      .cos_t(cos_t), .sin_t(sin_t), .cos_a(cos_a), .sin_a(sin_a),
      .center_x(center_x_ff), .center_y(center_y_ff),
      .semi_major(semi_major_ff), .semi_minor(semi_minor_ff),
      .out_tag(mac_tag), .out_x(out_x), .out_y(out_y),
      .point_valid(point_valid)
   );

   assign rsp_tvalid   = mac_tag.valid;
   assign rsp_tdata    = {out_y, out_x};
   assign rsp_tuser[0] = point_valid;

   // rejected vertices come out as the origin
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("invalid vertex with nonzero coordinates");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp item right after reset");

   // a held result freezes the pipeline
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

endmodule
